### design/xalu_pkg.sv
package xalu_pkg;

  // what an item asks for
  typedef enum logic [1:0] {
    ACT_ALU   = 2'd0,
    ACT_CMP   = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  // alu operation kinds, long (32-bit) and word (16-bit)
  typedef enum logic [4:0] {
    K_ADDL  = 5'd0,
    K_ADDW  = 5'd1,
    K_SUBL  = 5'd2,
    K_SUBW  = 5'd3,
    K_ANDL  = 5'd4,
    K_ANDW  = 5'd5,
    K_ORL   = 5'd6,
    K_ORW   = 5'd7,
    K_INCL  = 5'd8,
    K_INCW  = 5'd9,
    K_DECL  = 5'd10,
    K_DECW  = 5'd11,
    K_SHLL  = 5'd12,
    K_SHLW  = 5'd13,
    K_SARL  = 5'd14,
    K_SARW  = 5'd15,
    K_NEGL  = 5'd16,
    K_NEGW  = 5'd17,
    K_SBBL  = 5'd18,
    K_IMULL = 5'd19,
    K_IMULW = 5'd20
  } alu_kind_t;

  // test and compare kinds
  typedef enum logic [4:0] {
    C_TESTL = 5'd0,
    C_TESTW = 5'd1,
    C_TESTB = 5'd2,
    C_CMPL  = 5'd3,
    C_CMPW  = 5'd4,
    C_CMPB  = 5'd5
  } cmp_kind_t;

  // condition codes
  typedef enum logic [3:0] {
    CC_E  = 4'd0,
    CC_NE = 4'd1,
    CC_A  = 4'd2,
    CC_AE = 4'd3,
    CC_B  = 4'd4,
    CC_BE = 4'd5,
    CC_G  = 4'd6,
    CC_GE = 4'd7,
    CC_L  = 4'd8,
    CC_LE = 4'd9,
    CC_S  = 4'd10,
    CC_NS = 4'd11
  } cond_t;

  // internal operation classes
  typedef enum logic [3:0] {
    OP_NOP,
    OP_PASS,
    OP_ADD,
    OP_SUB,
    OP_AND,
    OP_OR,
    OP_INC,
    OP_DEC,
    OP_SHL,
    OP_SAR,
    OP_NEG,
    OP_SBB,
    OP_MUL
  } op_t;

  typedef enum logic [1:0] {
    W8,
    W16,
    W32
  } width_t;

  typedef struct packed {
    op_t    op;
    width_t width;
    logic   discard;   // flags only, result forced to zero
  } ctrl_t;

  typedef struct packed {
    logic ovf;
    logic carry;
    logic sign;
    logic zero;
  } flags_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SHAMT_W = 5;

endpackage

### design/x86_style_alu_with_flags_top.sv
// channel | handshake            | payload
// --------+----------------------+--------------------------------------------------
// in      | in_valid / in_ready  | in_action, in_op_kind, in_a_operand,
//         |                      | in_b_operand, in_condition_code
// out     | out_valid / out_ready| out_result, out_zero_out, out_sign_out,
//         |                      | out_carry_out, out_overflow_out, out_condition_true
//
// one item per cycle unless out_ready stalls; path: input register, then result register
// the flag register is written as an item moves into the result register, so the
// next item already sees the updated flags without a bubble
// reset (rst_n low, synchronous) clears both valid bits and all four flags
// a stalled result holds; the input register still takes one more item behind it

module x86_style_alu_with_flags_top
  import xalu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [4:0]        in_op_kind,
  input  logic [DATA_W-1:0] in_a_operand,
  input  logic [DATA_W-1:0] in_b_operand,
  input  logic [3:0]        in_condition_code,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_result,
  output logic              out_zero_out,
  output logic              out_sign_out,
  output logic              out_carry_out,
  output logic              out_overflow_out,
  output logic              out_condition_true
);

  // input register stage
  logic              s1_vld_r;
  logic [1:0]        s1_action_r;
  logic [4:0]        s1_kind_r;
  logic [DATA_W-1:0] s1_a_r;
  logic [DATA_W-1:0] s1_b_r;
  logic [3:0]        s1_cond_r;

  // result register stage and architectural flags
  logic              out_vld_r;
  logic [DATA_W-1:0] result_r;
  logic              cond_hit_r;
  flags_t            flags_r;

  ctrl_t             ctrl;
  logic [DATA_W-1:0] exec_res;
  flags_t            flags_nxt;
  logic              cond_hit;
  logic              out_free;
  logic              advance;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_vld_r || out_ready;
  assign advance  = s1_vld_r && out_free;
  assign in_ready = !s1_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_kind_r   <= in_op_kind;
      s1_a_r      <= in_a_operand;
      s1_b_r      <= in_b_operand;
      s1_cond_r   <= in_condition_code;
    end
  end

  xalu_dec u_dec (
    .action (s1_action_r),
    .kind   (s1_kind_r),
    .ctrl   (ctrl)
  );

  xalu_exec u_exec (
    .ctrl      (ctrl),
    .a         (s1_a_r),
    .b         (s1_b_r),
    .flags_in  (flags_r),
    .result    (exec_res),
    .flags_out (flags_nxt)
  );

  // condition sees the flags as they stand after this item
  xalu_cond u_cond (
    .flags (flags_nxt),
    .code  (s1_cond_r),
    .hit   (cond_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      flags_r   <= '0;
    end else begin
      if (out_free) begin
        out_vld_r <= s1_vld_r;
      end
      if (advance) begin
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r   <= exec_res;
      cond_hit_r <= cond_hit;
    end
  end

  // flags_r only changes when a new item enters the result register,
  // so it always matches the item on display
  assign out_valid          = out_vld_r;
  assign out_result         = result_r;
  assign out_zero_out       = flags_r.zero;
  assign out_sign_out       = flags_r.sign;
  assign out_carry_out      = flags_r.carry;
  assign out_overflow_out   = flags_r.ovf;
  assign out_condition_true = cond_hit_r;

endmodule

### design/xalu_dec.sv
module xalu_dec
  import xalu_pkg::*;
(
  input  logic [1:0] action,
  input  logic [4:0] kind,
  output ctrl_t      ctrl
);

  always_comb begin
    ctrl.op      = OP_NOP;
    ctrl.width   = W32;
    ctrl.discard = 1'b0;
    unique case (action)
      ACT_ALU: begin
        unique case (kind) inside
          K_ADDL, K_ADDW:   ctrl.op = OP_ADD;
          K_SUBL, K_SUBW:   ctrl.op = OP_SUB;
          K_ANDL, K_ANDW:   ctrl.op = OP_AND;
          K_ORL, K_ORW:     ctrl.op = OP_OR;
          K_INCL, K_INCW:   ctrl.op = OP_INC;
          K_DECL, K_DECW:   ctrl.op = OP_DEC;
          K_SHLL, K_SHLW:   ctrl.op = OP_SHL;
          K_SARL, K_SARW:   ctrl.op = OP_SAR;
          K_NEGL, K_NEGW:   ctrl.op = OP_NEG;
          K_SBBL:           ctrl.op = OP_SBB;
          K_IMULL, K_IMULW: ctrl.op = OP_MUL;
          default:          ctrl.op = OP_PASS;
        endcase
        unique case (kind) inside
          K_ADDW, K_SUBW, K_ANDW, K_ORW, K_INCW, K_DECW, K_SHLW, K_SARW, K_NEGW,
          K_IMULW: ctrl.width = W16;
          default: ctrl.width = W32;
        endcase
      end
      ACT_CMP: begin
        ctrl.discard = 1'b1;
        unique case (kind)
          C_TESTL: begin ctrl.op = OP_AND; ctrl.width = W32; end
          C_TESTW: begin ctrl.op = OP_AND; ctrl.width = W16; end
          C_TESTB: begin ctrl.op = OP_AND; ctrl.width = W8;  end
          C_CMPL:  begin ctrl.op = OP_SUB; ctrl.width = W32; end
          C_CMPW:  begin ctrl.op = OP_SUB; ctrl.width = W16; end
          C_CMPB:  begin ctrl.op = OP_SUB; ctrl.width = W8;  end
          default: ctrl.op = OP_NOP;
        endcase
      end
      default: ctrl.op = OP_NOP;
    endcase
  end

endmodule

### design/xalu_exec.sv
module xalu_exec
  import xalu_pkg::*;
(
  input  ctrl_t              ctrl,
  input  logic [DATA_W-1:0]  a,
  input  logic [DATA_W-1:0]  b,
  input  flags_t             flags_in,
  output logic [DATA_W-1:0]  result,
  output flags_t             flags_out
);

  function automatic logic [DATA_W-1:0] msk(logic [DATA_W-1:0] v, width_t w);
    case (w)
      W8:      return {24'd0, v[7:0]};
      W16:     return {16'd0, v[15:0]};
      default: return v;
    endcase
  endfunction

  function automatic logic msb(logic [DATA_W-1:0] v, width_t w);
    case (w)
      W8:      return v[7];
      W16:     return v[15];
      default: return v[31];
    endcase
  endfunction

  function automatic logic cbit(logic [DATA_W:0] v, width_t w);
    case (w)
      W8:      return v[8];
      W16:     return v[16];
      default: return v[32];
    endcase
  endfunction

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1);

  width_t              w;
  logic [SHAMT_W-1:0]  shamt;
  logic [DATA_W-1:0]   ma, mb;
  logic [DATA_W-1:0]   add_src, add_r;
  logic [DATA_W:0]     add_sum;
  logic                add_c, add_o;
  logic [DATA_W-1:0]   sub_min, sub_sth, sub_r;
  logic [DATA_W:0]     sub_dif;
  logic                sub_c, sub_o;
  logic [DATA_W+1:0]   sbb_s, sbb_u;
  logic                sbb_c, sbb_o;
  logic [DATA_W-1:0]   sar_v, shl_r, sar_r, mul_p, logic_r;
  logic [DATA_W-1:0]   res;
  logic                upd_zs, upd_co;
  logic                new_c, new_o;

  always_comb begin
    w     = ctrl.width;
    shamt = a[SHAMT_W-1:0];
    ma    = msk(a, w);
    mb    = msk(b, w);

    // add / inc
    add_src = (ctrl.op == OP_INC) ? ONE : ma;
    add_sum = {1'b0, mb} + {1'b0, add_src};
    add_r   = msk(add_sum[DATA_W-1:0], w);
    add_c   = cbit(add_sum, w);
    add_o   = (msb(mb, w) == msb(add_src, w)) && (msb(add_r, w) != msb(mb, w));

    // sub / dec / neg (neg is 0 - b)
    sub_min = (ctrl.op == OP_NEG) ? '0 : mb;
    sub_sth = (ctrl.op == OP_NEG) ? mb : ((ctrl.op == OP_DEC) ? ONE : ma);
    sub_dif = {1'b0, sub_min} - {1'b0, sub_sth};
    sub_r   = msk(sub_dif[DATA_W-1:0], w);
    sub_c   = sub_dif[DATA_W];
    sub_o   = (msb(sub_min, w) != msb(sub_sth, w)) && (msb(sub_r, w) != msb(sub_min, w));

    // subtract with borrow, exact signed and unsigned range checks
    sbb_s = {{2{b[DATA_W-1]}}, b} - {{2{a[DATA_W-1]}}, a} - {{(DATA_W+1){1'b0}}, flags_in.carry};
    sbb_u = {2'b00, b} - {2'b00, a} - {{(DATA_W+1){1'b0}}, flags_in.carry};
    sbb_c = sbb_u[DATA_W+1];
    sbb_o = !((sbb_s[DATA_W+1:DATA_W-1] == 3'b000) || (sbb_s[DATA_W+1:DATA_W-1] == 3'b111));

    // shifts
    shl_r = msk(b << shamt, w);
    sar_v = (w == W16) ? {{16{b[15]}}, b[15:0]} : b;
    sar_r = msk(DATA_W'($signed(sar_v) >>> shamt), w);

    mul_p   = a * b;
    logic_r = msk((ctrl.op == OP_OR) ? (a | b) : (a & b), w);

    res    = '0;
    upd_zs = 1'b1;
    upd_co = 1'b1;
    new_c  = flags_in.carry;
    new_o  = flags_in.ovf;
    case (ctrl.op)
      OP_ADD: begin res = add_r; new_c = add_c; new_o = add_o; end
      OP_INC: begin res = add_r; new_o = add_o; end
      OP_SUB, OP_NEG: begin res = sub_r; new_c = sub_c; new_o = sub_o; end
      OP_DEC: begin res = sub_r; new_o = sub_o; end
      OP_AND, OP_OR: begin res = logic_r; new_c = 1'b0; new_o = 1'b0; end
      OP_SHL: begin res = shl_r; upd_co = 1'b0; end
      OP_SAR: begin res = sar_r; upd_co = 1'b0; end
      OP_SBB: begin res = sbb_u[DATA_W-1:0]; new_c = sbb_c; new_o = sbb_o; end
      OP_MUL: begin res = msk(mul_p, w); upd_zs = 1'b0; upd_co = 1'b0; end
      OP_PASS: begin res = b; upd_zs = 1'b0; upd_co = 1'b0; end
      default: begin upd_zs = 1'b0; upd_co = 1'b0; end
    endcase

    flags_out.zero  = upd_zs ? (res == '0) : flags_in.zero;
    flags_out.sign  = upd_zs ? msb(res, w) : flags_in.sign;
    flags_out.carry = upd_co ? new_c : flags_in.carry;
    flags_out.ovf   = upd_co ? new_o : flags_in.ovf;
    result          = ctrl.discard ? '0 : res;
  end

endmodule

### design/xalu_cond.sv
module xalu_cond
  import xalu_pkg::*;
(
  input  flags_t     flags,
  input  logic [3:0] code,
  output logic       hit
);

  always_comb begin
    unique case (code)
      CC_E:    hit = flags.zero;
      CC_NE:   hit = !flags.zero;
      CC_A:    hit = !flags.carry && !flags.zero;
      CC_AE:   hit = !flags.carry;
      CC_B:    hit = flags.carry;
      CC_BE:   hit = flags.carry || flags.zero;
      CC_G:    hit = !flags.zero && (flags.sign == flags.ovf);
      CC_GE:   hit = flags.sign == flags.ovf;
      CC_L:    hit = flags.sign != flags.ovf;
      CC_LE:   hit = flags.zero || (flags.sign != flags.ovf);
      CC_S:    hit = flags.sign;
      CC_NS:   hit = !flags.sign;
      default: hit = 1'b0;
    endcase
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import xalu_pkg::*;
();

  // action code with no enum member: the block treats it as a flag query
  localparam logic [1:0] ACT_RESERVED = 2'd3;
  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 4000;
  // settle time after the last result (two-stage pipe plus margin)
  localparam int DRAIN_CYCLES = 8;
  // cap on printed mismatch lines, counting goes on past it
  localparam int PRINT_CAP = 100;

  // one input item as the bus carries it
  typedef struct {
    logic [1:0]  action;
    logic [4:0]  kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [3:0]  cc;
  } alu_op_t;

  // one result item: value, flags after the step, condition outcome
  typedef struct {
    logic [31:0] result;
    flags_t      flags;
    logic        cond_true;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [4:0]  in_op_kind = '0;
  logic [31:0] in_a_operand = '0;
  logic [31:0] in_b_operand = '0;
  logic [3:0]  in_condition_code = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result;
  logic        out_zero_out;
  logic        out_sign_out;
  logic        out_carry_out;
  logic        out_overflow_out;
  logic        out_condition_true;

  // items waiting to be driven, results waiting to come back
  alu_op_t     pending_ops[$];
  alu_result_t alu_expected[$];

  // predictor copy of the flag register
  flags_t      flag_state = '0;

  alu_op_t     bus_op;
  alu_result_t front_result;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  logic [3:0]  next_cc = '0;

  x86_style_alu_with_flags_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_op_kind         (in_op_kind),
    .in_a_operand       (in_a_operand),
    .in_b_operand       (in_b_operand),
    .in_condition_code  (in_condition_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result         (out_result),
    .out_zero_out       (out_zero_out),
    .out_sign_out       (out_sign_out),
    .out_carry_out      (out_carry_out),
    .out_overflow_out   (out_overflow_out),
    .out_condition_true (out_condition_true)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // flag and result prediction
  // ---------------------------------------------------------------------

  function automatic logic [31:0] width_mask(input logic [31:0] v, input width_t w);
    case (w)
      W8:      return {24'h0, v[7:0]};
      W16:     return {16'h0, v[15:0]};
      default: return v;
    endcase
  endfunction

  function automatic logic width_msb(input logic [31:0] v, input width_t w);
    case (w)
      W8:      return v[7];
      W16:     return v[15];
      default: return v[31];
    endcase
  endfunction

  // word-sized alu kinds; everything else (sbb included) is long
  function automatic width_t kind_width(input logic [4:0] kind);
    case (kind)
      K_ADDW, K_SUBW, K_ANDW, K_ORW, K_INCW, K_DECW,
      K_SHLW, K_SARW, K_NEGW, K_IMULW: return W16;
      default:                         return W32;
    endcase
  endfunction

  function automatic width_t cmp_width(input logic [4:0] kind);
    case (kind)
      C_TESTB, C_CMPB: return W8;
      C_TESTW, C_CMPW: return W16;
      default:         return W32;
    endcase
  endfunction

  function automatic void set_zero_sign(input logic [31:0] r, input width_t w);
    flag_state.zero = (r == 32'h0);
    flag_state.sign = width_msb(r, w);
  endfunction

  // and, or, test: carry and overflow cleared
  function automatic void logic_flags(input logic [31:0] r, input width_t w);
    set_zero_sign(width_mask(r, w), w);
    flag_state.carry = 1'b0;
    flag_state.ovf   = 1'b0;
  endfunction

  // b + a at width w; inc passes keep_carry
  function automatic logic [31:0] add_and_flag(input logic [31:0] a, input logic [31:0] b,
                                               input width_t w, input logic keep_carry);
    logic [31:0] ma, mb, r;
    ma = width_mask(a, w);
    mb = width_mask(b, w);
    r  = width_mask(mb + ma, w);
    set_zero_sign(r, w);
    if (!keep_carry) flag_state.carry = (r < mb);
    flag_state.ovf = (width_msb(mb, w) == width_msb(ma, w)) &&
                     (width_msb(r, w) != width_msb(mb, w));
    return r;
  endfunction

  // b - a at width w; dec passes keep_carry
  function automatic logic [31:0] sub_and_flag(input logic [31:0] a, input logic [31:0] b,
                                               input width_t w, input logic keep_carry);
    logic [31:0] ma, mb, r;
    ma = width_mask(a, w);
    mb = width_mask(b, w);
    r  = width_mask(mb - ma, w);
    set_zero_sign(r, w);
    if (!keep_carry) flag_state.carry = (mb < ma);
    flag_state.ovf = (width_msb(mb, w) != width_msb(ma, w)) &&
                     (width_msb(r, w) != width_msb(mb, w));
    return r;
  endfunction

  function automatic logic cond_holds(input logic [3:0] cc, input flags_t f);
    case (cc)
      CC_E:    return f.zero;
      CC_NE:   return !f.zero;
      CC_A:    return !f.carry && !f.zero;
      CC_AE:   return !f.carry;
      CC_B:    return f.carry;
      CC_BE:   return f.carry || f.zero;
      CC_G:    return !f.zero && (f.sign == f.ovf);
      CC_GE:   return f.sign == f.ovf;
      CC_L:    return f.sign != f.ovf;
      CC_LE:   return f.zero || (f.sign != f.ovf);
      CC_S:    return f.sign;
      CC_NS:   return !f.sign;
      default: return 1'b0;  // undefined condition codes never hold
    endcase
  endfunction

  // advances flag_state by one accepted item and returns its result item
  function automatic alu_result_t predict_alu_step(input alu_op_t op);
    alu_result_t res;
    width_t      w;
    logic [31:0] v;
    logic        carry_in;
    longint      diff;
    res.result = '0;
    if (op.action == ACT_ALU) begin
      w = kind_width(op.kind);
      case (op.kind)
        K_ADDL, K_ADDW: res.result = add_and_flag(op.a, op.b, w, 1'b0);
        K_SUBL, K_SUBW: res.result = sub_and_flag(op.a, op.b, w, 1'b0);
        K_ANDL, K_ANDW: begin
          res.result = width_mask(op.a & op.b, w);
          logic_flags(res.result, w);
        end
        K_ORL, K_ORW: begin
          res.result = width_mask(op.a | op.b, w);
          logic_flags(res.result, w);
        end
        K_INCL, K_INCW: res.result = add_and_flag(32'h1, op.b, w, 1'b1);
        K_DECL, K_DECW: res.result = sub_and_flag(32'h1, op.b, w, 1'b1);
        // shifts touch zero and sign only, even for a zero count
        K_SHLL, K_SHLW: begin
          res.result = width_mask(op.b << op.a[4:0], w);
          set_zero_sign(res.result, w);
        end
        K_SARL, K_SARW: begin
          v = (w == W16) ? {{16{op.b[15]}}, op.b[15:0]} : op.b;
          res.result = width_mask($signed(v) >>> op.a[4:0], w);
          set_zero_sign(res.result, w);
        end
        K_NEGL, K_NEGW: begin
          res.result = sub_and_flag(op.b, 32'h0, w, 1'b0);
          flag_state.carry = (width_mask(op.b, w) != 32'h0);
        end
        // borrow and overflow of the exact b - a - carry
        K_SBBL: begin
          carry_in   = flag_state.carry;
          res.result = op.b - op.a - {31'h0, carry_in};
          diff = longint'($signed(op.b)) - longint'($signed(op.a)) - longint'(carry_in);
          set_zero_sign(res.result, W32);
          flag_state.carry = ({1'b0, op.b} < ({1'b0, op.a} + {32'h0, carry_in}));
          flag_state.ovf   = (diff[63:31] != '0) && (diff[63:31] != '1);
        end
        K_IMULL, K_IMULW: res.result = width_mask(op.a * op.b, w);
        default: res.result = op.b;  // unknown kind passes b through
      endcase
    end else if (op.action == ACT_CMP) begin
      case (op.kind)
        C_TESTL, C_TESTW, C_TESTB: logic_flags(op.a & op.b, cmp_width(op.kind));
        C_CMPL, C_CMPW, C_CMPB: void'(sub_and_flag(op.a, op.b, cmp_width(op.kind), 1'b0));
        default: ;  // unknown compare leaves flags alone
      endcase
    end
    res.flags     = flag_state;
    res.cond_true = cond_holds(op.cc, flag_state);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // directed item, condition code walks through all sixteen values
  task automatic push_op(input logic [1:0] act, input logic [4:0] kind,
                         input logic [31:0] a, input logic [31:0] b);
    alu_op_t op;
    op.action = act;
    op.kind   = kind;
    op.a      = a;
    op.b      = b;
    op.cc     = next_cc;
    next_cc   = next_cc + 4'd1;
    pending_ops.push_back(op);
  endtask

  // operands biased toward carry, sign and overflow boundaries
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      4:       return 32'($urandom_range(0, 40));
      5:       return $urandom & 32'h0000_ffff;
      6:       return {($urandom_range(0, 1) ? 16'hffff : 16'h0000),
                       (16'h8000 - 16'($urandom_range(0, 1)))};
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_ops(input int count);
    alu_op_t op;
    int      pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        op.action = ACT_ALU;
        op.kind = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(21, 31))
                                              : 5'($urandom_range(0, 20));
      end else if (pick < 87) begin
        op.action = ACT_CMP;
        op.kind = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(6, 31))
                                              : 5'($urandom_range(0, 5));
      end else begin
        op.action = (pick < 95) ? ACT_QUERY : ACT_RESERVED;
        op.kind   = 5'($urandom_range(0, 31));
      end
      op.a  = rand_operand();
      op.b  = rand_operand();
      op.cc = 4'($urandom_range(0, 15));
      pending_ops.push_back(op);
    end
  endtask

  // every queued item has been taken by the block
  task automatic wait_sent();
    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t: mismatch on %s, got %h, want %h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // driver: one payload register, refilled from pending_ops
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // the item on the bus is taken at this edge
      if (in_valid && in_ready) begin
        alu_expected.push_back(predict_alu_step(bus_op));
      end
      // the bus is free after this edge: offer the next item or idle
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          bus_op            = pending_ops.pop_front();
          in_valid          <= 1'b1;
          in_action         <= bus_op.action;
          in_op_kind        <= bus_op.kind;
          in_a_operand      <= bus_op.a;
          in_b_operand      <= bus_op.b;
          in_condition_code <= bus_op.cc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: random back-pressure and field by field check
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (alu_expected.size() == 0) begin
          report_mismatch("unexpected result item", out_result, 32'h0);
        end else begin
          front_result = alu_expected.pop_front();
          if (out_result !== front_result.result)
            report_mismatch("result", out_result, front_result.result);
          if (out_zero_out !== front_result.flags.zero)
            report_mismatch("zero flag", 32'(out_zero_out),
                            32'(front_result.flags.zero));
          if (out_sign_out !== front_result.flags.sign)
            report_mismatch("sign flag", 32'(out_sign_out),
                            32'(front_result.flags.sign));
          if (out_carry_out !== front_result.flags.carry)
            report_mismatch("carry flag", 32'(out_carry_out),
                            32'(front_result.flags.carry));
          if (out_overflow_out !== front_result.flags.ovf)
            report_mismatch("overflow flag", 32'(out_overflow_out),
                            32'(front_result.flags.ovf));
          if (out_condition_true !== front_result.cond_true)
            report_mismatch("condition", 32'(out_condition_true),
                            32'(front_result.cond_true));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog: no handshake on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("[x86_style_alu_with_flags_top] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: width boundaries, every operation and the odd cases
    push_op(ACT_ALU, K_ADDL, 32'h0000_0001, 32'hffff_ffff);  // carry out, zero
    push_op(ACT_ALU, K_ADDL, 32'h0000_0001, 32'h7fff_ffff);  // signed overflow
    push_op(ACT_ALU, K_ADDW, 32'h0000_0001, 32'hffff_ffff);  // word wrap, upper bits dropped
    push_op(ACT_ALU, K_SUBW, 32'h0000_0001, 32'h0000_8000);  // word overflow
    push_op(ACT_ALU, K_SUBL, 32'h0000_0001, 32'h0000_0000);  // borrow sets carry
    push_op(ACT_ALU, K_SBBL, 32'hffff_ffff, 32'h0000_0000);  // a plus carry exceeds 32 bits
    push_op(ACT_ALU, K_SBBL, 32'h0000_0000, 32'h8000_0000);  // overflow only via carry
    push_op(ACT_ALU, K_INCL, 32'h0000_0000, 32'hffff_ffff);  // carry kept
    push_op(ACT_ALU, K_DECW, 32'hffff_ffff, 32'h0000_0000);  // word underflow, carry kept
    push_op(ACT_ALU, K_ANDL, 32'hf0f0_f0f0, 32'h0f0f_0f0f);
    push_op(ACT_ALU, K_ORW,  32'h0000_8000, 32'hffff_0000);
    push_op(ACT_ALU, K_SHLL, 32'h0000_001f, 32'h0000_0001);  // top bit count
    push_op(ACT_ALU, K_SHLW, 32'h0000_0000, 32'h0000_ffff);  // zero count still sets flags
    push_op(ACT_ALU, K_SARL, 32'h0000_001f, 32'h8000_0000);
    push_op(ACT_ALU, K_SARW, 32'h0000_0024, 32'h0000_8000);  // count taken mod 32
    push_op(ACT_ALU, K_NEGL, 32'h0000_0000, 32'h0000_0000);
    push_op(ACT_ALU, K_NEGL, 32'h0000_0000, 32'h8000_0000);
    push_op(ACT_ALU, K_NEGW, 32'hffff_ffff, 32'hffff_0001);
    push_op(ACT_ALU, K_IMULL, 32'hffff_ffff, 32'hffff_ffff); // flags untouched
    push_op(ACT_ALU, K_IMULW, 32'h0000_ffff, 32'h0000_8001);
    push_op(ACT_ALU, 5'd31, 32'hffff_ffff, 32'hdead_beef);   // unknown kind: b through
    push_op(ACT_CMP, C_TESTL, 32'h8000_0000, 32'hffff_ffff);
    push_op(ACT_CMP, C_TESTW, 32'hffff_0000, 32'hffff_0000);
    push_op(ACT_CMP, C_TESTB, 32'h0000_0080, 32'h0000_00ff);
    push_op(ACT_CMP, C_CMPL, 32'hffff_ffff, 32'h0000_0000);
    push_op(ACT_CMP, C_CMPW, 32'h0000_0001, 32'h0000_8000);
    push_op(ACT_CMP, C_CMPB, 32'h0000_0080, 32'h0000_007f);
    push_op(ACT_CMP, 5'd31, 32'h0000_0000, 32'h0000_0000);   // unknown compare
    push_op(ACT_QUERY, 5'd0, 32'hffff_ffff, 32'hffff_ffff);
    push_op(ACT_RESERVED, 5'd31, 32'hffff_ffff, 32'hffff_ffff);
    wait_sent();

    // random phases with different idling patterns
    send_idle_pct = 0;  stall_pct = 0;  queue_random_ops(360); wait_sent();
    send_idle_pct = 76; stall_pct = 0;  queue_random_ops(360); wait_sent();
    send_idle_pct = 0;  stall_pct = 76; queue_random_ops(360); wait_sent();
    send_idle_pct = 34; stall_pct = 34; queue_random_ops(360); wait_sent();

    // let the last results drain, then allow a few stray cycles
    stall_pct = 0;
    while (alu_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[x86_style_alu_with_flags_top] OK");
    end else begin
      $display("[x86_style_alu_with_flags_top] ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/xalu_pkg.sv
design/xalu_dec.sv
design/xalu_exec.sv
design/xalu_cond.sv
design/x86_style_alu_with_flags_top.sv
tb/sv/tb_top.sv
